// File: sv/kekt_pkg.sv
// ----------------------------------------------------------------------------
// kekt_pkg: shared types and tables for the keypad event key translator
// Holds the key kind codes, grid constants, the queue word layout and the
// three keymap layers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kekt_pkg;

   // Event byte layout
   localparam int EVENT_W      = 8;
   localparam logic [7:0] PRESS_MASK = 8'h80;
   localparam logic [7:0] CODE_MASK  = 8'h7F;

   // Grid geometry
   localparam int SCAN_COLS    = 10;
   localparam int GRID_COLS    = 14;
   localparam int GRID_KEYS    = 56;
   localparam int IDX_W        = 6;

   // Reciprocal for the divide by ten: q = (c * 205) >> 11, exact for c < 1029
   localparam logic [7:0] DIV10_MUL   = 8'd205;
   localparam int         DIV10_SHIFT = 11;

   // Modifier key positions (visual row, visual column)
   localparam logic [1:0] MOD_ROW   = 2'd2;
   localparam logic [3:0] SHIFT_COL = 4'd1;
   localparam logic [3:0] FN_COL    = 4'd0;

   // Queue depth default
   localparam int QUEUE_DEPTH = 2;

   // Key kinds
   localparam logic [3:0] KIND_NONE  = 4'd0;
   localparam logic [3:0] KIND_CHAR  = 4'd1;
   localparam logic [3:0] KIND_SPACE = 4'd2;

   // ROM entry coding
   localparam logic [6:0] ENTRY_SPACE = 7'd32;
   localparam logic [6:0] ENTRY_NONE  = 7'd11;
   localparam logic [6:0] ENTRY_NOFN  = 7'd0;

   // One classified key event handed from front to back
   typedef struct packed {
      logic [1:0] vis_row;
      logic [3:0] vis_col;
      logic       pressed;
      logic       shift_held;
      logic       fn_held;
   } kekt_item_type;

   typedef logic [6:0] kekt_layer_type [0:GRID_KEYS-1];

   localparam kekt_layer_type PLAIN_LAYER = '{
      7'h60, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
      7'h30, 7'h2D, 7'h3D, 7'd4,
      7'd5,  7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
      7'h70, 7'h5B, 7'h5D, 7'h5C,
      7'd11, 7'd11, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
      7'h6C, 7'h3B, 7'h27, 7'd3,
      7'd11, 7'd11, 7'd11, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D,
      7'h2C, 7'h2E, 7'h2F, 7'h20
   };

   localparam kekt_layer_type SHIFT_LAYER = '{
      7'h7E, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28,
      7'h29, 7'h5F, 7'h2B, 7'd4,
      7'd5,  7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
      7'h50, 7'h7B, 7'h7D, 7'h7C,
      7'd11, 7'd11, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
      7'h4C, 7'h3A, 7'h22, 7'd3,
      7'd11, 7'd11, 7'd11, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D,
      7'h3C, 7'h3E, 7'h3F, 7'h20
   };

   localparam kekt_layer_type FN_LAYER = '{
      7'd6,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
      7'd0,  7'd0,  7'd0,  7'd4,
      7'd0,  7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
      7'h50, 7'd0,  7'd0,  7'd0,
      7'd0,  7'd0,  7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
      7'h4C, 7'd7,  7'd0,  7'd0,
      7'd0,  7'd0,  7'd0,  7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D,
      7'd9,  7'd8,  7'd10, 7'd0
   };

endpackage

`default_nettype wire

// File: sv/kekt_front.sv
// ----------------------------------------------------------------------------
// kekt_front: event byte decode and modifier tracking
// Splits the key code into visual row and column, drops empty and
// out-of-grid codes, tracks shift and fn, and pushes key words to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kekt_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [kekt_pkg::EVENT_W-1:0] req_event_byte,
   output logic                              push_valid,
   input  wire logic                         push_ready,
   output kekt_pkg::kekt_item_type           push_item
);

   logic        shift_ff, shift_in;
   logic        fn_ff, fn_in;
   logic [6:0]  code;
   logic [6:0]  code_m1;
   logic [14:0] prod;
   logic [3:0]  srow;
   logic [6:0]  rem_full;
   logic [3:0]  scol;
   logic [4:0]  vcol;
   logic [1:0]  vrow;
   logic        is_press;
   logic        drop;
   logic        is_shift;
   logic        is_fn;
   logic        accept;

   // Split code minus one by ten through the reciprocal
   always_comb begin
      code     = req_event_byte[6:0] & kekt_pkg::CODE_MASK[6:0];
      is_press = (req_event_byte & kekt_pkg::PRESS_MASK) != 8'd0;
      code_m1  = code - 7'd1;
      prod     = 15'(code_m1) * 15'(kekt_pkg::DIV10_MUL);
      srow     = 4'(prod >> kekt_pkg::DIV10_SHIFT);
      rem_full = code_m1 - 7'(srow) * 7'(kekt_pkg::SCAN_COLS);
      scol     = rem_full[3:0];
      vcol     = {srow, 1'b0} + ((scol > 4'd3) ? 5'd1 : 5'd0);
      vrow     = scol[1:0];
      drop     = (code == 7'd0) || (vcol >= 5'(kekt_pkg::GRID_COLS));
      is_shift = (vrow == kekt_pkg::MOD_ROW) && (vcol[3:0] == kekt_pkg::SHIFT_COL);
      is_fn    = (vrow == kekt_pkg::MOD_ROW) && (vcol[3:0] == kekt_pkg::FN_COL);
   end

   // Stall only when the queue is full
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // Forward ordinary keys with the modifier state seen at their arrival
   assign push_valid           = req_valid && !drop && !is_shift && !is_fn;
   assign push_item.vis_row    = vrow;
   assign push_item.vis_col    = vcol[3:0];
   assign push_item.pressed    = is_press;
   assign push_item.shift_held = shift_ff;
   assign push_item.fn_held    = fn_ff;

   // Update held modifiers
   always_comb begin
      shift_in = shift_ff;
      fn_in    = fn_ff;
      if (accept && !drop && is_shift) begin
         shift_in = is_press;
      end
      if (accept && !drop && is_fn) begin
         fn_in = is_press;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         fn_ff    <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         fn_ff    <= fn_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/kekt_queue.sv
// ----------------------------------------------------------------------------
// kekt_queue: small word queue between front and back
// A register FIFO; ready is held low only while every slot is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kekt_queue #(
   parameter int DEPTH = kekt_pkg::QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   output logic                         push_ready,
   input  wire kekt_pkg::kekt_item_type push_item,
   output logic                         pop_valid,
   input  wire logic                    pop_ready,
   output kekt_pkg::kekt_item_type      pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   kekt_pkg::kekt_item_type slot_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: sv/kekt_back.sv
// ----------------------------------------------------------------------------
// kekt_back: keymap lookup and result register
// Picks the fn, shift or plain layer, decodes the entry into kind and
// character, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kekt_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   output logic                         pop_ready,
   input  wire kekt_pkg::kekt_item_type pop_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_vis_row,
   output logic [3:0]                   rsp_vis_col,
   output logic                         rsp_pressed,
   output logic [3:0]                   rsp_key_kind,
   output logic [6:0]                   rsp_char_code
);

   logic                          valid_ff, valid_in;
   logic [1:0]                    row_ff;
   logic [3:0]                    col_ff;
   logic                          pressed_ff;
   logic [3:0]                    kind_ff, kind_in;
   logic [6:0]                    char_ff, char_in;
   logic [kekt_pkg::IDX_W-1:0]    idx;
   logic [6:0]                    fn_entry;
   logic [6:0]                    entry;
   logic                          do_pop;

   // Accept a new word when the result register is empty or draining
   assign pop_ready = !valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;

   // Look up and decode the keymap entry
   always_comb begin
      idx = {pop_item.vis_row, 4'd0} - {3'd0, pop_item.vis_row, 1'b0}
            + {2'd0, pop_item.vis_col};
      fn_entry = kekt_pkg::FN_LAYER[idx];
      priority if (pop_item.fn_held && fn_entry != kekt_pkg::ENTRY_NOFN) begin
         entry = fn_entry;
      end else if (pop_item.shift_held) begin
         entry = kekt_pkg::SHIFT_LAYER[idx];
      end else begin
         entry = kekt_pkg::PLAIN_LAYER[idx];
      end
      kind_in = kekt_pkg::KIND_NONE;
      char_in = 7'd0;
      if (pop_item.pressed) begin
         priority if (entry == kekt_pkg::ENTRY_SPACE) begin
            kind_in = kekt_pkg::KIND_SPACE;
            char_in = entry;
         end else if (entry > kekt_pkg::ENTRY_SPACE) begin
            kind_in = kekt_pkg::KIND_CHAR;
            char_in = entry;
         end else if (entry != kekt_pkg::ENTRY_NONE) begin
            kind_in = entry[3:0];
         end else begin
            kind_in = kekt_pkg::KIND_NONE;
         end
      end
   end

   // Hold the result valid until taken
   always_comb begin
      valid_in = valid_ff;
      if (do_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         row_ff     <= pop_item.vis_row;
         col_ff     <= pop_item.vis_col;
         pressed_ff <= pop_item.pressed;
         kind_ff    <= kind_in;
         char_ff    <= char_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_vis_row   = row_ff;
   assign rsp_vis_col   = col_ff;
   assign rsp_pressed   = pressed_ff;
   assign rsp_key_kind  = kind_ff;
   assign rsp_char_code = char_ff;

endmodule

`default_nettype wire

// File: sv/keypad_event_key_translator_top.sv
// ----------------------------------------------------------------------------
// keypad_event_key_translator_top: keypad scanner event to key event
// Usage:
//   req channel: one scanner event byte per word (bit 7 press, bits 6..0
//   key code plus one). Empty codes, out-of-grid keys and the shift and fn
//   keys are consumed without a result; shift and fn update held state.
//   rsp channel: visual row and column, press flag, key kind and ASCII
//   character for each other key.
//   Throughput: one event per cycle while a queue slot is free, set by the
//   combinational decode in the front and keymap lookup in the back.
//   Path: an accepted event is registered in a queue slot and then in the
//   result register, which drives rsp_valid.
//   Stalls: when the receiver holds rsp_ready low, the result register
//   holds, the queue fills, and req_ready drops once every queue slot is
//   taken. Events without a result also wait while the queue is full.
//   Reset: clears shift and fn state, empties the queue and the result
//   register; req_ready is high once reset has emptied the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keypad_event_key_translator_top #(
   parameter int QUEUE_DEPTH = kekt_pkg::QUEUE_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [kekt_pkg::EVENT_W-1:0] req_event_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_vis_row,
   output logic [3:0]                        rsp_vis_col,
   output logic                              rsp_pressed,
   output logic [3:0]                        rsp_key_kind,
   output logic [6:0]                        rsp_char_code
);

   logic                    push_valid;
   logic                    push_ready;
   kekt_pkg::kekt_item_type push_item;
   logic                    pop_valid;
   logic                    pop_ready;
   kekt_pkg::kekt_item_type pop_item;

   kekt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_event_byte (req_event_byte),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   kekt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   kekt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_vis_row   (rsp_vis_row),
      .rsp_vis_col   (rsp_vis_col),
      .rsp_pressed   (rsp_pressed),
      .rsp_key_kind  (rsp_key_kind),
      .rsp_char_code (rsp_char_code)
   );

endmodule

`default_nettype wire
